@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the lighting unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define BPL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed: lbl");

// Same-cycle implication.
`define BPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

`endif

@@ hw/rtl/bpl_pkg.sv @@
// Shared types and constants of the Blinn-Phong lighting unit.
package bpl_pkg;

  localparam int CfgW    = 48;
  localparam int CfgIdxW = 3;
  localparam int CoefW   = 16;
  localparam int TexW    = 8;

  // Target range of the scaled magnitude before the square root: [2^29, 2^30).
  localparam int MagBits = 30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X   = 3'd0,
    CFG_ROW_Y   = 3'd1,
    CFG_ROW_Z   = 3'd2,
    CFG_ROW_W   = 3'd3,
    CFG_LIGHT   = 3'd4,
    CFG_DEF_EXP = 3'd5
  } cfg_idx_e;

  localparam logic [CfgW-1:0] RowXRst  = 48'd16384;
  localparam logic [CfgW-1:0] RowYRst  = 48'd1073741824;
  localparam logic [CfgW-1:0] RowZRst  = 48'd70368744177664;
  localparam logic [CfgW-1:0] RowWRst  = 48'd0;
  localparam logic [CfgW-1:0] LightRst = 48'd70368744177664;
  localparam logic [7:0]      DefExpRst = 8'd50;

  // Pull coefficient k out of a packed x,y,z register.
  function automatic logic signed [CoefW-1:0] coef(input logic [CfgW-1:0] p, input int k);
    coef = $signed(p[CoefW*k +: CoefW]);
  endfunction

endpackage

@@ hw/rtl/bpl_norm.sv @@
// Pipelined 3-vector normalizer: scale, square root and divide stages.
module bpl_norm
  import bpl_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int IN_W      = 34,
  parameter int SIDE_W    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [2:0][IN_W-1:0]             vec_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [2:0][FRAC_BITS+1:0]        vec_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int IDX_W = $clog2(IN_W);
  localparam int SW    = IN_W + MagBits;
  localparam int SQ_W  = 2 * MagBits;
  localparam int X_W   = SQ_W + 2;
  localparam int REM_W = 34;
  localparam int RT_W  = 31;
  localparam int SQ_IT = X_W / 2;
  localparam int SQ_ST = (SQ_IT + 1) / 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int O_W   = FRAC_BITS + 2;
  localparam int NW    = MagBits + FRAC_BITS + 1;
  localparam int R_W   = 32;
  localparam int DV_IT = Q_W;
  localparam int DV_ST = (DV_IT + 1) / 2;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              zero;
    logic [2:0]        sgn;
  } tag_t;

  // Stage 0: magnitudes and signs
  logic                       s0_v_q;
  tag_t                       s0_tag_q;
  logic [2:0][IN_W-1:0]       s0_abs_q;
  // Stage 1: leading one
  logic                       s1_v_q;
  tag_t                       s1_tag_q;
  logic [2:0][IN_W-1:0]       s1_abs_q;
  logic [IDX_W-1:0]           s1_msb_q, s1_msb_d;
  // Stage 2: scaled components
  logic                       s2_v_q;
  tag_t                       s2_tag_q;
  logic [2:0][MagBits-1:0]    s2_a_q, s2_a_d;
  // Stage 3: squares
  logic                       s3_v_q;
  tag_t                       s3_tag_q;
  logic [2:0][MagBits-1:0]    s3_a_q;
  logic [2:0][SQ_W-1:0]       s3_sq_q;
  // Square root stages
  logic                       sq_v_q   [SQ_ST+1];
  tag_t                       sq_tag_q [SQ_ST+1], sq_tag_d [SQ_ST+1];
  logic [2:0][MagBits-1:0]    sq_a_q   [SQ_ST+1], sq_a_d   [SQ_ST+1];
  logic [X_W-1:0]             sq_x_q   [SQ_ST+1], sq_x_d   [SQ_ST+1];
  logic [REM_W-1:0]           sq_rem_q [SQ_ST+1], sq_rem_d [SQ_ST+1];
  logic [RT_W-1:0]            sq_rt_q  [SQ_ST+1], sq_rt_d  [SQ_ST+1];
  // Divide stages
  logic                       dv_v_q   [DV_ST+1];
  tag_t                       dv_tag_q [DV_ST+1], dv_tag_d [DV_ST+1];
  logic [RT_W-1:0]            dv_mag_q [DV_ST+1], dv_mag_d [DV_ST+1];
  logic [2:0][R_W-1:0]        dv_r_q   [DV_ST+1], dv_r_d   [DV_ST+1];
  logic [2:0][Q_W-1:0]        dv_low_q [DV_ST+1], dv_low_d [DV_ST+1];
  logic [2:0][Q_W-1:0]        dv_quo_q [DV_ST+1], dv_quo_d [DV_ST+1];
  logic [2:0][O_W-1:0]        vec_d;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      valid_o <= 1'b0;
      for (int k = 0; k <= SQ_ST; k++) sq_v_q[k] <= 1'b0;
      for (int k = 0; k <= DV_ST; k++) dv_v_q[k] <= 1'b0;
    end else if (en_i) begin
      s0_v_q    <= valid_i;
      s1_v_q    <= s0_v_q;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      sq_v_q[0] <= s3_v_q;
      for (int k = 0; k < SQ_ST; k++) sq_v_q[k+1] <= sq_v_q[k];
      dv_v_q[0] <= sq_v_q[SQ_ST];
      for (int k = 0; k < DV_ST; k++) dv_v_q[k+1] <= dv_v_q[k];
      valid_o   <= dv_v_q[DV_ST];
    end
  end

  // Find the leading one of the OR of all magnitudes
  always_comb begin : msb_comb
    logic [IN_W-1:0] orv;
    orv = s0_abs_q[0] | s0_abs_q[1] | s0_abs_q[2];
    s1_msb_d = '0;
    for (int j = 0; j < IN_W; j++) begin
      if (orv[j]) s1_msb_d = IDX_W'(j);
    end
  end

  // Shift so the largest magnitude lands in [2^29, 2^30)
  always_comb begin : shift_comb
    logic [SW-1:0] ext;
    logic [SW-1:0] sh;
    int m;
    m = int'(s1_msb_q);
    for (int i = 0; i < 3; i++) begin
      ext = SW'(s1_abs_q[i]);
      if (m >= MagBits - 1) sh = ext >> (m - (MagBits - 1));
      else                  sh = ext << ((MagBits - 1) - m);
      s2_a_d[i] = sh[MagBits-1:0];
    end
  end

  // Front stages: abs, msb, shift, square
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s0_abs_q[i]   <= vec_i[i][IN_W-1] ? (~vec_i[i] + IN_W'(1)) : vec_i[i];
        s0_tag_q.sgn[i] <= vec_i[i][IN_W-1];
        s3_sq_q[i]    <= SQ_W'(s2_a_q[i]) * SQ_W'(s2_a_q[i]);
      end
      s0_tag_q.zero <= (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
      s0_tag_q.side <= side_i;
      s1_abs_q <= s0_abs_q;
      s1_tag_q <= s0_tag_q;
      s1_msb_q <= s1_msb_d;
      s2_tag_q <= s1_tag_q;
      s2_a_q   <= s2_a_d;
      s3_tag_q <= s2_tag_q;
      s3_a_q   <= s2_a_q;
    end
  end

  // Integer square root, two result bits per stage
  always_comb begin : sqrt_comb
    logic [X_W-1:0]   x;
    logic [REM_W-1:0] rem, remt, trial;
    logic [RT_W-1:0]  rt;
    sq_x_d[0]   = X_W'(s3_sq_q[0]) + X_W'(s3_sq_q[1]) + X_W'(s3_sq_q[2]);
    sq_rem_d[0] = '0;
    sq_rt_d[0]  = '0;
    sq_a_d[0]   = s3_a_q;
    sq_tag_d[0] = s3_tag_q;
    for (int k = 0; k < SQ_ST; k++) begin
      x   = sq_x_q[k];
      rem = sq_rem_q[k];
      rt  = sq_rt_q[k];
      for (int it = 0; it < 2; it++) begin
        if (2 * k + it < SQ_IT) begin
          remt  = {rem[REM_W-3:0], x[X_W-1:X_W-2]};
          trial = REM_W'({rt, 2'b01});
          if (remt >= trial) begin
            rem = remt - trial;
            rt  = {rt[RT_W-2:0], 1'b1};
          end else begin
            rem = remt;
            rt  = {rt[RT_W-2:0], 1'b0};
          end
          x = x << 2;
        end
      end
      sq_x_d[k+1]   = x;
      sq_rem_d[k+1] = rem;
      sq_rt_d[k+1]  = rt;
      sq_a_d[k+1]   = sq_a_q[k];
      sq_tag_d[k+1] = sq_tag_q[k];
    end
  end

  // Rounded division a * 2^F / mag, two quotient bits per stage
  always_comb begin : div_comb
    logic [NW-1:0]   num;
    logic [R_W:0]    t;
    logic [R_W-1:0]  r;
    logic [Q_W-1:0]  low, quo;
    dv_mag_d[0] = sq_rt_q[SQ_ST];
    dv_tag_d[0] = sq_tag_q[SQ_ST];
    for (int i = 0; i < 3; i++) begin
      num = NW'({sq_a_q[SQ_ST][i], {FRAC_BITS{1'b0}}}) + NW'(sq_rt_q[SQ_ST] >> 1);
      dv_r_d[0][i]   = R_W'(num[NW-1:Q_W]);
      dv_low_d[0][i] = num[Q_W-1:0];
      dv_quo_d[0][i] = '0;
    end
    for (int k = 0; k < DV_ST; k++) begin
      for (int i = 0; i < 3; i++) begin
        r   = dv_r_q[k][i];
        low = dv_low_q[k][i];
        quo = dv_quo_q[k][i];
        for (int it = 0; it < 2; it++) begin
          if (2 * k + it < DV_IT) begin
            t = {r, low[Q_W-1]};
            if (t >= (R_W+1)'(dv_mag_q[k])) begin
              t   = t - (R_W+1)'(dv_mag_q[k]);
              quo = {quo[Q_W-2:0], 1'b1};
            end else begin
              quo = {quo[Q_W-2:0], 1'b0};
            end
            r   = t[R_W-1:0];
            low = low << 1;
          end
        end
        dv_r_d[k+1][i]   = r;
        dv_low_d[k+1][i] = low;
        dv_quo_d[k+1][i] = quo;
      end
      dv_mag_d[k+1] = dv_mag_q[k];
      dv_tag_d[k+1] = dv_tag_q[k];
    end
  end

  // Put the signs back; an all-zero vector stays zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_tag_q[DV_ST].zero)        vec_d[i] = '0;
      else if (dv_tag_q[DV_ST].sgn[i]) vec_d[i] = ~O_W'(dv_quo_q[DV_ST][i]) + O_W'(1);
      else                             vec_d[i] = O_W'(dv_quo_q[DV_ST][i]);
    end
  end

  // Advance the root and divide pipelines
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= SQ_ST; k++) begin
        sq_x_q[k]   <= sq_x_d[k];
        sq_rem_q[k] <= sq_rem_d[k];
        sq_rt_q[k]  <= sq_rt_d[k];
        sq_a_q[k]   <= sq_a_d[k];
        sq_tag_q[k] <= sq_tag_d[k];
      end
      for (int k = 0; k <= DV_ST; k++) begin
        dv_mag_q[k] <= dv_mag_d[k];
        dv_tag_q[k] <= dv_tag_d[k];
        dv_r_q[k]   <= dv_r_d[k];
        dv_low_q[k] <= dv_low_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
      end
      vec_o  <= vec_d;
      side_o <= dv_tag_q[DV_ST].side;
    end
  end

endmodule

@@ hw/rtl/blinn_phong_fragment_lighting_unit.sv @@
// Blinn-Phong fragment lighting unit: transform, normalize, dot, power, color.
//
// Input channel: one fragment per beat (texel color, normal-map normal, optional
// specular exponent), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one lit RGB color per fragment, in order, offered on
// out_valid_o and taken when out_stall_i is low.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0..5:
// matrix rows x, y, z, w, light vector, default exponent); write only when idle.
// Throughput: one fragment per cycle while the output is not stalled. Every
// stage is a register slice. The path runs through two normalizers in series
// (31-bit square root at two bits per stage, then the divide) and the power
// ladder with one multiply per stage.
// Reset clears all valid bits and loads the identity matrix, light (0,0,1)
// and default exponent 50. When the receiver stalls a finished result, the
// whole pipeline holds and in_stall_o rises in the same cycle; nothing is
// dropped or repeated.
`include "assert_macros.svh"

module blinn_phong_fragment_lighting_unit
  import bpl_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int EXP_BITS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         texel_red_i,
  input  logic [7:0]         texel_green_i,
  input  logic [7:0]         texel_blue_i,
  input  logic signed [15:0] map_normal_x_i,
  input  logic signed [15:0] map_normal_y_i,
  input  logic signed [15:0] map_normal_z_i,
  input  logic               spec_present_i,
  input  logic [7:0]         spec_exponent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o
);

  localparam int PRD_W = 2 * CoefW;
  localparam int V_W   = PRD_W + 2;
  localparam int O_W   = FRAC_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int H_W   = FRAC_BITS + 3;
  localparam int DP_W  = 2 * O_W;
  localparam int DS_W  = DP_W + 2;
  localparam int PW_ST = 2 * EXP_BITS;
  localparam int M_W   = 2 * FRAC_BITS + 2;
  localparam int CK_W  = M_W + TexW;
  localparam int CS_W  = CK_W + 1;
  localparam logic [Q_W-1:0]  One   = Q_W'(1) << FRAC_BITS;
  localparam logic [2*Q_W-1:0] Half = (2*Q_W)'(1) << (FRAC_BITS - 1);
  localparam logic [Q_W-1:0]  C12   = Q_W'(((12 << FRAC_BITS) + 5) / 10);
  localparam logic [Q_W-1:0]  C06   = Q_W'(((6 << FRAC_BITS) + 5) / 10);
  localparam logic [CS_W-1:0] Bias  = CS_W'(20) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [3*TexW-1:0]     tex;
    logic [EXP_BITS-1:0]   expo;
    logic [2:0][O_W-1:0]   n;
    logic [2:0][O_W-1:0]   l;
  } hside_t;

  logic adv;

  // Configuration registers
  logic [CfgW-1:0] row_q [4];
  logic [CfgW-1:0] light_q;
  logic [7:0]      def_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]  <= RowXRst;
      row_q[1]  <= RowYRst;
      row_q[2]  <= RowZRst;
      row_q[3]  <= RowWRst;
      light_q   <= LightRst;
      def_exp_q <= DefExpRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_X:   row_q[0]  <= cfg_data_i;
        CFG_ROW_Y:   row_q[1]  <= cfg_data_i;
        CFG_ROW_Z:   row_q[2]  <= cfg_data_i;
        CFG_ROW_W:   row_q[3]  <= cfg_data_i;
        CFG_LIGHT:   light_q   <= cfg_data_i;
        CFG_DEF_EXP: def_exp_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a finished result is held
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Transform stages
  logic                      p1_v_q, p2_v_q;
  logic signed [PRD_W-1:0]   p1_prod_q [4][3];
  logic [3*TexW-1:0]         p1_tex_q, p2_tex_q;
  logic [EXP_BITS-1:0]       p1_exp_q, p2_exp_q;
  logic signed [V_W-1:0]     p2_v3_q [3];
  logic                      p2_wneg_q;
  logic signed [V_W-1:0]     sum_d [4];
  logic [2:0][CoefW-1:0]     nm;
  logic [7:0]                exp8;

  assign nm[0] = map_normal_x_i;
  assign nm[1] = map_normal_y_i;
  assign nm[2] = map_normal_z_i;
  assign exp8  = spec_present_i ? spec_exponent_i : def_exp_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = V_W'(p1_prod_q[r][0]) + V_W'(p1_prod_q[r][1]) + V_W'(p1_prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_prod_q[r][c] <= PRD_W'(coef(row_q[r], c)) * PRD_W'($signed(nm[c]));
        end
      end
      p1_tex_q  <= {texel_blue_i, texel_green_i, texel_red_i};
      p1_exp_q  <= EXP_BITS'(exp8);
      for (int r = 0; r < 3; r++) p2_v3_q[r] <= sum_d[r];
      p2_wneg_q <= sum_d[3] < 0;
      p2_tex_q  <= p1_tex_q;
      p2_exp_q  <= p1_exp_q;
    end
  end

  // Normal and light normalizers run side by side
  logic [2:0][V_W-1:0]   nvec_in;
  logic [2:0][CoefW-1:0] lvec_in;
  logic                  nv_valid, lv_valid;
  logic [2:0][O_W-1:0]   n_vec, l_vec;
  logic [3*TexW-1:0]     n_tex;
  logic [EXP_BITS-1:0]   l_exp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvec_in[i] = p2_wneg_q ? -p2_v3_q[i] : p2_v3_q[i];
      lvec_in[i] = light_q[CoefW*i +: CoefW];
    end
  end

  bpl_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(V_W), .SIDE_W(3*TexW)) u_norm_n (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p2_v_q), .vec_i(nvec_in), .side_i(p2_tex_q),
    .valid_o(nv_valid), .vec_o(n_vec), .side_o(n_tex)
  );

  bpl_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(CoefW), .SIDE_W(EXP_BITS)) u_norm_l (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p2_v_q), .vec_i(lvec_in), .side_i(p2_exp_q),
    .valid_o(lv_valid), .vec_o(l_vec), .side_o(l_exp)
  );

  // Half vector normalizer
  logic [2:0][H_W-1:0] hvec_in;
  hside_t              h_side_in, h_side;
  logic                hv_valid;
  logic [2:0][O_W-1:0] h_vec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hvec_in[i] = H_W'($signed(n_vec[i])) + H_W'($signed(l_vec[i]));
    end
    h_side_in.tex  = n_tex;
    h_side_in.expo = l_exp;
    h_side_in.n    = n_vec;
    h_side_in.l    = l_vec;
  end

  bpl_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(H_W), .SIDE_W($bits(hside_t))) u_norm_h (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(nv_valid), .vec_i(hvec_in), .side_i(h_side_in),
    .valid_o(hv_valid), .vec_o(h_vec), .side_o(h_side)
  );

  // Dot product stages
  logic                    d1_v_q;
  logic signed [DP_W-1:0]  d1_nl_q [3], d1_nh_q [3];
  logic [3*TexW-1:0]       d1_tex_q;
  logic [EXP_BITS-1:0]     d1_exp_q;
  logic [Q_W-1:0]          diff_d, base_d;

  function automatic logic [Q_W-1:0] pos_dot(input logic signed [DP_W-1:0] p0,
                                             input logic signed [DP_W-1:0] p1,
                                             input logic signed [DP_W-1:0] p2);
    logic signed [DS_W-1:0] s;
    logic signed [DS_W-1:0] r;
    s = DS_W'(p0) + DS_W'(p1) + DS_W'(p2);
    r = (s + DS_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (s <= 0)                  pos_dot = '0;
    else if (r > DS_W'(One))     pos_dot = One;
    else                         pos_dot = r[Q_W-1:0];
  endfunction

  assign diff_d = pos_dot(d1_nl_q[0], d1_nl_q[1], d1_nl_q[2]);
  assign base_d = pos_dot(d1_nh_q[0], d1_nh_q[1], d1_nh_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_nl_q[i] <= $signed(h_side.n[i]) * $signed(h_side.l[i]);
        d1_nh_q[i] <= $signed(h_side.n[i]) * $signed(h_vec[i]);
      end
      d1_tex_q <= h_side.tex;
      d1_exp_q <= h_side.expo;
    end
  end

  // Power ladder: square, then multiply by the base when the bit is set
  logic                 pw_v_q    [PW_ST+1];
  logic [Q_W-1:0]       pw_r_q    [PW_ST+1], pw_r_d [PW_ST+1];
  logic [Q_W-1:0]       pw_base_q [PW_ST+1];
  logic [Q_W-1:0]       pw_diff_q [PW_ST+1];
  logic [EXP_BITS-1:0]  pw_e_q    [PW_ST+1];
  logic [3*TexW-1:0]    pw_tex_q  [PW_ST+1];

  always_comb begin : pow_comb
    logic [2*Q_W-1:0] m;
    pw_r_d[0] = One;
    for (int j = 0; j < PW_ST; j++) begin
      if ((j & 1) == 0) begin
        m = (2*Q_W)'(pw_r_q[j]) * (2*Q_W)'(pw_r_q[j]) + Half;
        pw_r_d[j+1] = m[FRAC_BITS +: Q_W];
      end else if (pw_e_q[j][EXP_BITS-1-(j>>1)]) begin
        m = (2*Q_W)'(pw_r_q[j]) * (2*Q_W)'(pw_base_q[j]) + Half;
        pw_r_d[j+1] = m[FRAC_BITS +: Q_W];
      end else begin
        m = '0;
        pw_r_d[j+1] = pw_r_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw_r_q[0]    <= pw_r_d[0];
      pw_base_q[0] <= base_d;
      pw_diff_q[0] <= diff_d;
      pw_e_q[0]    <= d1_exp_q;
      pw_tex_q[0]  <= d1_tex_q;
      for (int j = 0; j < PW_ST; j++) begin
        pw_r_q[j+1]    <= pw_r_d[j+1];
        pw_base_q[j+1] <= pw_base_q[j];
        pw_diff_q[j+1] <= pw_diff_q[j];
        pw_e_q[j+1]    <= pw_e_q[j];
        pw_tex_q[j+1]  <= pw_tex_q[j];
      end
    end
  end

  // Color stages: weights, sum, scale, bias and saturate
  logic                c1_v_q, c2_v_q, c3_v_q;
  logic [M_W-1:0]      c1_m12_q, c1_m06_q, c2_k_q;
  logic [3*TexW-1:0]   c1_tex_q, c2_tex_q;
  logic [CK_W-1:0]     c3_prod_q [3];
  logic [7:0]          col_d [3];

  always_comb begin : sat_comb
    logic [CS_W-1:0] t;
    logic [CS_W-2*FRAC_BITS-1:0] r;
    for (int i = 0; i < 3; i++) begin
      t = CS_W'(c3_prod_q[i]) + Bias;
      r = t[CS_W-1:2*FRAC_BITS];
      col_d[i] = (r > 255) ? 8'd255 : r[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_m12_q <= M_W'(C12) * M_W'(pw_diff_q[PW_ST]);
      c1_m06_q <= M_W'(C06) * M_W'(pw_r_q[PW_ST]);
      c1_tex_q <= pw_tex_q[PW_ST];
      c2_k_q   <= c1_m12_q + c1_m06_q;
      c2_tex_q <= c1_tex_q;
      for (int i = 0; i < 3; i++) begin
        c3_prod_q[i] <= CK_W'(c2_tex_q[TexW*i +: TexW]) * CK_W'(c2_k_q);
      end
      out_red_o   <= col_d[0];
      out_green_o <= col_d[1];
      out_blue_o  <= col_d[2];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      d1_v_q      <= 1'b0;
      c1_v_q      <= 1'b0;
      c2_v_q      <= 1'b0;
      c3_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
      for (int j = 0; j <= PW_ST; j++) pw_v_q[j] <= 1'b0;
    end else if (adv) begin
      p1_v_q    <= in_valid_i;
      p2_v_q    <= p1_v_q;
      d1_v_q    <= hv_valid;
      pw_v_q[0] <= d1_v_q;
      for (int j = 0; j < PW_ST; j++) pw_v_q[j+1] <= pw_v_q[j];
      c1_v_q      <= pw_v_q[PW_ST];
      c2_v_q      <= c1_v_q;
      c3_v_q      <= c2_v_q;
      out_valid_o <= c3_v_q;
    end
  end

  // Checks
  `BPL_ASSERT_ALWAYS(a_norm_lanes_aligned, nv_valid == lv_valid)
  `BPL_ASSERT_IMP(a_stall_only_when_held, in_stall_o, out_valid_o && out_stall_i)
  `BPL_ASSERT_IMP(a_dots_in_range, pw_v_q[0], pw_base_q[0] <= One && pw_diff_q[0] <= One)

endmodule
